[rtl/ewsa_pkg.sv]
// shared constants, request codes and controller/datapath interface structs
// for the weighted scatter-accumulate combine engine
// no dependencies
package ewsa_pkg;

    // store geometry
    localparam int MAX_TOKENS = 256;
    localparam int TOP_K      = 8;
    localparam int HIDDEN_DIM = 64;

    localparam int W_DEPTH  = MAX_TOKENS * TOP_K;
    localparam int A_DEPTH  = MAX_TOKENS * HIDDEN_DIM;
    localparam int W_ADDR_W = $clog2(W_DEPTH);
    localparam int A_ADDR_W = $clog2(A_DEPTH);

    // field widths
    localparam int REQ_W   = 2;
    localparam int TOK_W   = 8;
    localparam int SLOT_W  = 3;
    localparam int ELEM_W  = 6;
    localparam int GW_W    = 16;
    localparam int EV_W    = 16;
    localparam int ACC_W   = 32;
    localparam int FRAC_SH = 15;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACCUM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic latch;     // capture the accepted word
        logic mul_step;  // register the weighted product
        logic acc_step;  // store updates and form the result
        logic out_load;  // move the result into the output register
        logic clr_step;  // zero one accumulator entry
    } ewsa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;  // held request is a clear
        logic clr_last;  // clear sweep at its final entry
    } ewsa_stat_t;

endpackage

[rtl/ewsa_dp.sv]
// datapath: request registers, weight and accumulator memories,
// multiply, saturating add, clear sweep counter and output register
// depends on ewsa_pkg
module ewsa_dp
    import ewsa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ewsa_cmd_t                cmd,
    output ewsa_stat_t               stat,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic [TOK_W-1:0]         s_token_index,
    input  logic [SLOT_W-1:0]        s_slot_index,
    input  logic [ELEM_W-1:0]        s_element_index,
    input  logic [GW_W-1:0]          s_gate_weight,
    input  logic signed [EV_W-1:0]   s_expert_value,
    output logic signed [ACC_W-1:0]  m_read_value,
    output logic                     m_status
);

    localparam int PROD_W = GW_W + 1 + EV_W;
    localparam int SUM_W  = ACC_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd1 <<< (ACC_W - 1));

    // captured request
    logic [REQ_W-1:0]        req_reg;
    logic [TOK_W-1:0]        tok_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [ELEM_W-1:0]       elem_reg;
    logic [GW_W-1:0]         gw_reg;
    logic signed [EV_W-1:0]  ev_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            req_reg  <= s_req_type;
            tok_reg  <= s_token_index;
            slot_reg <= s_slot_index;
            elem_reg <= s_element_index;
            gw_reg   <= s_gate_weight;
            ev_reg   <= s_expert_value;
        end
    end

    // address forming and range checks
    logic                tok_ok, slot_ok, elem_ok;
    logic                w_ok, a_ok;
    logic [W_ADDR_W-1:0] w_addr;
    logic [A_ADDR_W-1:0] a_addr;

    always_comb begin
        tok_ok  = int'(tok_reg) < MAX_TOKENS;
        slot_ok = int'(slot_reg) < TOP_K;
        elem_ok = int'(elem_reg) < HIDDEN_DIM;
        w_ok    = tok_ok && slot_ok;
        a_ok    = tok_ok && elem_ok;
        w_addr  = W_ADDR_W'(int'(tok_reg) * TOP_K + int'(slot_reg));
        a_addr  = A_ADDR_W'(int'(tok_reg) * HIDDEN_DIM + int'(elem_reg));
    end

    // clear sweep counter
    logic [A_ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                clr_last;

    assign clr_last = int'(clr_cnt_reg) == A_DEPTH - 1;

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_step) begin
            clr_cnt_next = clr_last ? '0 : clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // weight memory
    logic [GW_W-1:0] w_mem [W_DEPTH];
    logic [GW_W-1:0] w_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.acc_step && req_reg == REQ_WRITE && w_ok) begin
            w_mem[w_addr] <= gw_reg;
        end
        w_rd_reg <= w_mem[w_addr];
    end

    // weighted product
    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_step) begin
            prod_reg <= PROD_W'($signed({1'b0, w_rd_reg})) * PROD_W'(ev_reg);
        end
    end

    // floor shift and saturating add
    logic signed [ACC_W-1:0] a_rd_reg;
    logic signed [SUM_W-1:0] term, sum, sum_sat;
    logic                    sat;

    always_comb begin
        term    = SUM_W'(prod_reg >>> FRAC_SH);
        sum     = SUM_W'(a_rd_reg) + term;
        sat     = 1'b0;
        sum_sat = sum;
        if (sum > SAT_MAX) begin
            sum_sat = SAT_MAX;
            sat     = 1'b1;
        end else if (sum < SAT_MIN) begin
            sum_sat = SAT_MIN;
            sat     = 1'b1;
        end
    end

    // accumulator memory, single write port shared with the clear sweep
    logic signed [ACC_W-1:0] a_mem [A_DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            a_mem[clr_cnt_reg] <= '0;
        end else if (cmd.acc_step && req_reg == REQ_ACCUM && a_ok && w_ok) begin
            a_mem[a_addr] <= sum_sat[ACC_W-1:0];
        end
        a_rd_reg <= a_mem[a_addr];
    end

    // result and output registers
    logic signed [ACC_W-1:0] res_value_reg, out_value_reg;
    logic                    res_status_reg, out_status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.acc_step) begin
            res_value_reg  <= (req_reg == REQ_READ && a_ok) ? a_rd_reg : '0;
            res_status_reg <= req_reg == REQ_ACCUM && a_ok && w_ok && sat;
        end
        if (cmd.out_load) begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_read_value  = out_value_reg;
    assign m_status      = out_status_reg;
    assign stat.is_clear = req_reg == REQ_CLEAR;
    assign stat.clr_last = clr_last;

endmodule

[rtl/ewsa_ctrl.sv]
// controller: sequences one request at a time through read, multiply,
// accumulate and output, and runs the accumulator clear sweep
// depends on ewsa_pkg
module ewsa_ctrl
    import ewsa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output ewsa_cmd_t  cmd,
    input  ewsa_stat_t stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC: begin
                cmd.acc_step = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.is_clear ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("word accepted while another is in flight");

    // output register never overwritten while its word waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output word overwritten before taken");

    // a loaded result shows up as valid next cycle
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

    // sweep end returns to accepting words
    a_clear_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR && stat.clr_last) |=> s_ready)
        else $error("clear sweep did not hand back to idle");

endmodule

[rtl/expert_weighted_scatter_accumulate_core.sv]
// an accepted word passes through memory read, multiply and saturating add, and
// its result is loaded into the output register once that register is free; the
// controller steps a single request at a time and accepts no new word until then
// a clear word is answered, then the accumulator memory is zeroed one entry
// per cycle over all 16384 entries with s_ready low; the same sweep runs
// after reset (synchronous, active low aresetn); weights are not cleared
module expert_weighted_scatter_accumulate_core
    import ewsa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [REQ_W-1:0]         s_req_type,
    input  logic [TOK_W-1:0]         s_token_index,
    input  logic [SLOT_W-1:0]        s_slot_index,
    input  logic [ELEM_W-1:0]        s_element_index,
    input  logic [GW_W-1:0]          s_gate_weight,
    input  logic signed [EV_W-1:0]   s_expert_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ACC_W-1:0]  m_read_value,
    output logic                     m_status
);

    ewsa_cmd_t  cmd;
    ewsa_stat_t stat;

    // sequencing
    ewsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // storage and arithmetic
    ewsa_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_req_type      (s_req_type),
        .s_token_index   (s_token_index),
        .s_slot_index    (s_slot_index),
        .s_element_index (s_element_index),
        .s_gate_weight   (s_gate_weight),
        .s_expert_value  (s_expert_value),
        .m_read_value    (m_read_value),
        .m_status        (m_status)
    );

endmodule
